// ----- rtl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the MIDI message assembler
// Item types for the input and result channels, action codes and status
// byte constants.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int MIDI_WIDTH  = 8;
    localparam int DATA_WIDTH  = 7;
    localparam int WAIT_WIDTH  = 24;
    localparam int DELTA_WIDTH = 24;

    typedef enum logic [1:0] {
        ACT_MIDI  = 2'd0,
        ACT_WAIT  = 2'd1,
        ACT_ECHO  = 2'd2,
        ACT_SPARE = 2'd3
    } action_t;

    // upper nibble of a status byte
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;

    localparam logic [1:0] ARGS_NONE = 2'd0;
    localparam logic [1:0] ARGS_ONE  = 2'd1;
    localparam logic [1:0] ARGS_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]            action;
        logic [MIDI_WIDTH-1:0] midi_byte;
        logic [WAIT_WIDTH-1:0] wait_ticks;
    } in_item_t;

    typedef struct packed {
        logic [3:0]             message_type;
        logic [3:0]             channel;
        logic [DATA_WIDTH-1:0]  data_one;
        logic [DATA_WIDTH-1:0]  data_two;
        logic [DELTA_WIDTH-1:0] delta_ticks;
    } out_item_t;

endpackage

// ----- rtl/mma_in_if.sv -----
// ----------------------------------------------------------------------------
// mma_in_if: input channel of the MIDI message assembler
// Valid/ready channel carrying one MIDI byte or timer event per transfer.
// ----------------------------------------------------------------------------
interface mma_in_if;

    logic              valid;
    logic              ready;
    mma_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/mma_out_if.sv -----
// ----------------------------------------------------------------------------
// mma_out_if: result channel of the MIDI message assembler
// Valid/ready channel carrying one assembled channel message per transfer.
// ----------------------------------------------------------------------------
interface mma_out_if;

    logic               valid;
    logic               ready;
    mma_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/midi_message_assembler.sv -----
// Output: a message appears on the result channel in the cycle after the transfer
//   of its last data byte.
// Throughput: one input item per cycle; the input stalls only while a finished
//   message waits in the result register and the sink holds ready low.
// Reset: asynchronous, active low; clears running status, tick counts and the
//   result valid flag.
// ----------------------------------------------------------------------------
// midi_message_assembler: running-status MIDI channel message assembler
// Collects data bytes behind channel status bytes, emits complete messages
// with the tick delta since the previous message.
// ----------------------------------------------------------------------------
module midi_message_assembler #(
    parameter int TICK_WIDTH = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    mma_in_if.sink    in_ch,
    mma_out_if.source out_ch
);
    import mma_pkg::*;

    logic [MIDI_WIDTH-1:0] status_reg,    status_next;
    logic [1:0]            expected_reg,  expected_next;
    logic [1:0]            left_reg,      left_next;
    logic [DATA_WIDTH-1:0] hold_one_reg,  hold_one_next;
    logic [DATA_WIDTH-1:0] hold_two_reg,  hold_two_next;
    logic [TICK_WIDTH-1:0] cur_ticks_reg, cur_ticks_next;
    logic [TICK_WIDTH-1:0] last_ticks_reg, last_ticks_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg,  out_item_next;

    logic                  in_fire;
    logic                  emit;
    logic [1:0]            status_args;
    logic [1:0]            left_dec;
    logic                  first_arg;
    logic [TICK_WIDTH-1:0] tick_diff;
    in_item_t              item;

    assign item      = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign left_dec  = left_reg - 2'd1;
    assign first_arg = (left_reg == expected_reg);
    assign tick_diff = cur_ticks_reg - last_ticks_reg;

    always_comb
    begin
        case (item.midi_byte[7:4])
            KIND_SYSTEM:   status_args = ARGS_NONE;
            KIND_PROGRAM:  status_args = ARGS_ONE;
            KIND_PRESSURE: status_args = ARGS_ONE;
            default:       status_args = ARGS_TWO;
        endcase
    end

    always_comb
    begin
        status_next     = status_reg;
        expected_next   = expected_reg;
        left_next       = left_reg;
        hold_one_next   = hold_one_reg;
        hold_two_next   = hold_two_reg;
        cur_ticks_next  = cur_ticks_reg;
        last_ticks_next = last_ticks_reg;
        emit            = 1'b0;
        if (in_fire)
        begin
            case (action_t'(item.action))
                ACT_WAIT:
                begin
                    cur_ticks_next = TICK_WIDTH'(item.wait_ticks);
                end
                ACT_MIDI:
                begin
                    if (item.midi_byte[7])
                    begin
                        // new status: drop any partial message
                        status_next   = item.midi_byte;
                        expected_next = status_args;
                        left_next     = status_args;
                        hold_one_next = '0;
                        hold_two_next = '0;
                    end
                    else if (left_reg != ARGS_NONE)
                    begin
                        if (first_arg)
                            hold_one_next = item.midi_byte[DATA_WIDTH-1:0];
                        else
                            hold_two_next = item.midi_byte[DATA_WIDTH-1:0];
                        if (left_dec == ARGS_NONE)
                        begin
                            // message complete: re-arm for running status
                            emit            = 1'b1;
                            left_next       = expected_reg;
                            last_ticks_next = cur_ticks_reg;
                        end
                        else
                        begin
                            left_next = left_dec;
                        end
                    end
                end
                default:
                begin
                    // echo and unused codes: drop
                end
            endcase
        end
    end

    always_comb
    begin
        out_item_next.message_type = status_reg[7:4];
        out_item_next.channel      = status_reg[3:0];
        out_item_next.data_one     = first_arg ? item.midi_byte[DATA_WIDTH-1:0]
                                               : hold_one_reg;
        out_item_next.data_two     = first_arg ? hold_two_reg
                                               : item.midi_byte[DATA_WIDTH-1:0];
        out_item_next.delta_ticks  = DELTA_WIDTH'(tick_diff);
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= '0;
            expected_reg   <= '0;
            left_reg       <= '0;
            hold_one_reg   <= '0;
            hold_two_reg   <= '0;
            cur_ticks_reg  <= '0;
            last_ticks_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            status_reg     <= status_next;
            expected_reg   <= expected_next;
            left_reg       <= left_next;
            hold_one_reg   <= hold_one_next;
            hold_two_reg   <= hold_two_next;
            cur_ticks_reg  <= cur_ticks_next;
            last_ticks_reg <= last_ticks_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (emit)
            out_item_reg <= out_item_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for midi_message_assembler
// Drives MIDI bytes, timer events and ignored actions into the block and
// checks every assembled message against a running-status predictor. The
// directed cases come first, then random streams under three idling profiles.
// ----------------------------------------------------------------------------
module tb;

    import mma_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    mma_in_if  in_ch ();
    mma_out_if out_ch ();

    midi_message_assembler u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [7:0]             run_status;
    logic [1:0]             msg_len;
    logic [1:0]             bytes_left;
    logic [7:0]             first_data;
    logic [7:0]             second_data;
    logic [WAIT_WIDTH-1:0]  tick_now;
    logic [WAIT_WIDTH-1:0]  tick_last;

    out_item_t pending_msgs[$];

    int items_sent;
    int mismatches;
    int cycle_count;
    int src_idle_pct;
    int snk_idle_pct;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    function automatic logic [1:0] data_count(input logic [7:0] status);
        if (status[7:4] == KIND_SYSTEM)
            return ARGS_NONE;
        if (status[7:4] == KIND_PROGRAM || status[7:4] == KIND_PRESSURE)
            return ARGS_ONE;
        return ARGS_TWO;
    endfunction

    // Advance the predictor by one accepted item, queue a message if one completes.
    function automatic void assemble_message(input in_item_t it);
        out_item_t msg;
        if (it.action == ACT_WAIT)
        begin
            tick_now = it.wait_ticks;
            return;
        end
        if (it.action != ACT_MIDI)
            return;
        if (it.midi_byte[7])
        begin
            run_status  = it.midi_byte;
            msg_len     = data_count(it.midi_byte);
            bytes_left  = msg_len;
            first_data  = '0;
            second_data = '0;
            return;
        end
        if (bytes_left == ARGS_NONE)
            return;
        if (bytes_left == msg_len)
            first_data = it.midi_byte;
        else
            second_data = it.midi_byte;
        bytes_left = bytes_left - 2'd1;
        if (bytes_left != ARGS_NONE)
            return;
        bytes_left = msg_len;
        msg.message_type = run_status[7:4];
        msg.channel      = run_status[3:0];
        msg.data_one     = first_data[6:0];
        msg.data_two     = second_data[6:0];
        msg.delta_ticks  = tick_now - tick_last;
        tick_last = tick_now;
        pending_msgs.push_back(msg);
    endfunction

    function automatic in_item_t mk_byte(input logic [7:0] b);
        in_item_t it;
        it.action     = ACT_MIDI;
        it.midi_byte  = b;
        it.wait_ticks = WAIT_WIDTH'($urandom);
        return it;
    endfunction

    function automatic in_item_t mk_tick(input logic [WAIT_WIDTH-1:0] t);
        in_item_t it;
        it.action     = ACT_WAIT;
        it.midi_byte  = 8'($urandom);
        it.wait_ticks = t;
        return it;
    endfunction

    function automatic in_item_t mk_other(input action_t a);
        in_item_t it;
        it.action     = a;
        it.midi_byte  = 8'($urandom);
        it.wait_ticks = WAIT_WIDTH'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] rand_channel_status();
        logic [3:0] kind;
        kind = 4'($urandom_range(8, 14));
        return {kind, 4'($urandom)};
    endfunction

    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        assemble_message(it);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (pending_msgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected message: type %h ch %h d1 %h d2 %h delta %h",
                             got.message_type, got.channel, got.data_one,
                             got.data_two, got.delta_ticks);
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (got.message_type !== want.message_type ||
                    got.channel !== want.channel ||
                    got.data_one !== want.data_one ||
                    got.data_two !== want.data_two ||
                    got.delta_ticks !== want.delta_ticks)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp type %h ch %h d1 %h d2 %h delta %h, ",
                                  "got type %h ch %h d1 %h d2 %h delta %h"},
                                 want.message_type, want.channel, want.data_one,
                                 want.data_two, want.delta_ticks,
                                 got.message_type, got.channel, got.data_one,
                                 got.data_two, got.delta_ticks);
                end
            end
        end
    end

    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_item(mk_byte(8'h05));             // data with no status yet: drop
        send_item(mk_other(ACT_ECHO));
        send_item(mk_other(ACT_SPARE));
        send_item(mk_tick(24'h000000));
        send_item(mk_byte(8'h90));
        send_item(mk_byte(8'h00));
        send_item(mk_byte(8'h7F));
        send_item(mk_tick(24'hFFFFFF));
        send_item(mk_byte(8'h7F));             // running status, two data bytes
        send_item(mk_byte(8'h00));
        send_item(mk_tick(24'h000004));        // delta wraps past zero
        send_item(mk_byte(8'hCF));
        send_item(mk_byte(8'h7F));
        send_item(mk_byte(8'h01));             // running program change
        send_item(mk_byte(8'hF0));
        send_item(mk_byte(8'h12));             // ignored after system status
        send_item(mk_byte(8'hFF));
        send_item(mk_byte(8'h80));
        send_item(mk_byte(8'h40));
        send_item(mk_byte(8'hEA));             // new status mid-message
        send_item(mk_byte(8'h55));
        send_item(mk_byte(8'h2A));
        send_item(mk_byte(8'hD3));
        send_item(mk_byte(8'h00));
        send_item(mk_byte(8'hA7));
        send_item(mk_byte(8'h3C));
        send_item(mk_byte(8'h41));
    endtask

    task automatic send_running_burst();
        logic [7:0] status;
        int         n_msgs;
        status = rand_channel_status();
        n_msgs = $urandom_range(1, 4);
        send_item(mk_byte(status));
        repeat (n_msgs)
        begin
            if ($urandom_range(0, 1))
                send_item(mk_tick(WAIT_WIDTH'($urandom)));
            send_item(mk_byte(8'($urandom_range(0, 127))));
            if (data_count(status) == ARGS_TWO)
                send_item(mk_byte(8'($urandom_range(0, 127))));
        end
    endtask

    // Start a two-byte message and leave it unfinished.
    task automatic send_broken_message();
        logic [3:0] kind;
        kind = 4'($urandom_range(8, 12));
        if (kind == KIND_PROGRAM)
            kind = 4'hE;
        send_item(mk_byte({kind, 4'($urandom)}));
        send_item(mk_byte(8'($urandom_range(0, 127))));
        if ($urandom_range(0, 1))
            send_item(mk_byte({KIND_SYSTEM, 4'($urandom)}));
    endtask

    task automatic test_stream(input int src_idle, input int snk_idle, input int count);
        int stop_at;
        int pick;
        src_idle_pct = src_idle;
        snk_idle_pct = snk_idle;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_running_burst();
            else if (pick < 70)
                send_item(mk_tick(WAIT_WIDTH'($urandom)));
            else if (pick < 78)
                send_item(mk_byte(8'($urandom_range(0, 127))));
            else if (pick < 84)
                send_item(mk_byte({KIND_SYSTEM, 4'($urandom)}));
            else if (pick < 90)
                send_item(mk_other($urandom_range(0, 1) ? ACT_ECHO : ACT_SPARE));
            else
                send_broken_message();
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        run_status     = '0;
        msg_len        = ARGS_NONE;
        bytes_left     = ARGS_NONE;
        first_data     = '0;
        second_data    = '0;
        tick_now       = '0;
        tick_last      = '0;
        items_sent     = 0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_stream(15, 67, 260);
        test_stream(67, 15, 260);
        test_stream(0, 0, 260);
        finish_run();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
